// ===== hdl/quote_bracket_aware_field_scanner_defines.svh =====
// assertion macros for the field scanner
`ifndef QUOTE_BRACKET_AWARE_FIELD_SCANNER_DEFINES_SVH
`define QUOTE_BRACKET_AWARE_FIELD_SCANNER_DEFINES_SVH

`ifndef SYNTHESIS
`define QBFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define QBFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define QBFS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define QBFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/qbfs_pkg.sv =====
// types, codes and character constants for the field scanner
`timescale 1ns / 1ps

package qbfs_pkg;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  localparam logic [1:0] KIND_PAREN   = 2'd0;
  localparam logic [1:0] KIND_SQUARE  = 2'd1;
  localparam logic [1:0] KIND_CURLY   = 2'd2;

  localparam logic [1:0] ST_DELIM     = 2'd0;
  localparam logic [1:0] ST_UNTERM    = 2'd1;
  localparam logic [1:0] ST_END       = 2'd2;
  localparam logic [1:0] ST_END_ERR   = 2'd3;

  localparam logic [1:0] REG_START    = 2'd0;
  localparam logic [1:0] REG_DELIMS   = 2'd1;
  localparam logic [1:0] REG_COUNT    = 2'd2;
  localparam logic [1:0] REG_EOE      = 2'd3;

  typedef enum logic [3:0] {
    MODE_PLAIN        = 4'b0001,
    MODE_STRING       = 4'b0010,
    MODE_BLOCK        = 4'b0100,
    MODE_BLOCK_STRING = 4'b1000
  } scan_mode_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] kind;
  } bracket_t;

  function automatic bracket_t open_kind(input logic [7:0] c);
    bracket_t b;
    b.hit  = 1'b1;
    b.kind = KIND_PAREN;
    case (c)
      8'h28:   b.kind = KIND_PAREN;
      8'h5B:   b.kind = KIND_SQUARE;
      8'h7B:   b.kind = KIND_CURLY;
      default: b.hit  = 1'b0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] open_char(input logic [1:0] kind);
    logic [7:0] c;
    case (kind)
      KIND_SQUARE: c = 8'h5B;
      KIND_CURLY:  c = 8'h7B;
      default:     c = 8'h28;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] close_char(input logic [1:0] kind);
    logic [7:0] c;
    case (kind)
      KIND_SQUARE: c = 8'h5D;
      KIND_CURLY:  c = 8'h7D;
      default:     c = 8'h29;
    endcase
    return c;
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    return (c == CH_DQUOTE) || (c == CH_SQUOTE);
  endfunction

endpackage

// ===== hdl/quote_bracket_aware_field_scanner.sv =====
// each input transfer is held in the input register, and a field result is then written to the result register
// throughput: one byte per cycle while out_tready stays high
// all per-byte work is combinational logic between the input register and the scan state and result registers
// rst_n is synchronous, active low: clears scan state, loads position 0, error_on_end 1
`timescale 1ns / 1ps

`include "quote_bracket_aware_field_scanner_defines.svh"

module quote_bracket_aware_field_scanner
  import qbfs_pkg::*;
#(
  parameter int NEST_LIMIT     = 255,
  parameter int MAX_DELIMITERS = 8,
  parameter int POSITION_BITS  = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_addr,
  input  logic [63:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // stop_position, field_first, field_last, field_empty, pad
  output logic [1:0]   out_tuser   // status
);

  localparam int DW = $clog2(NEST_LIMIT + 1);
  localparam logic [DW-1:0] DEPTH_MAX = DW'(NEST_LIMIT);
  localparam logic [DW-1:0] DEPTH_ONE = DW'(1);
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  // configuration
  logic [31:0] start_r;
  logic [63:0] delims_r;
  logic [3:0]  count_r;
  logic        eoe_r;

  // input register
  logic       in_valid_r;
  logic [7:0] byte_r;
  logic       last_r;

  // scan state
  scan_mode_t               mode_r, mode_nxt;
  logic [7:0]               quote_r, quote_nxt;
  logic [1:0]               kind_r, kind_nxt;
  logic [DW-1:0]            depth_r, depth_nxt;
  logic                     esc_r, esc_nxt;
  logic                     started_r, started_nxt;
  logic [POSITION_BITS-1:0] first_r, first_nxt;
  logic [POSITION_BITS-1:0] last_pos_r, last_pos_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;

  // result register
  logic        out_valid_r;
  logic [1:0]  status_r;
  logic [31:0] stop_r, res_first_r, res_last_r;
  logic        empty_r;

  logic        out_free, advance;
  logic        hit, err, delim;
  logic [1:0]  status_c;
  logic [31:0] res_first_c, res_last_c;
  logic        empty_c;
  bracket_t    br;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_comb begin
    delim = (byte_r == CH_NUL);
    for (int i = 0; i < MAX_DELIMITERS; i++) begin
      if ((4'(i) < count_r) && (delims_r[8*i +: 8] == byte_r)) begin
        delim = 1'b1;
      end
    end
  end

  always_comb begin
    mode_nxt     = mode_r;
    quote_nxt    = quote_r;
    kind_nxt     = kind_r;
    depth_nxt    = depth_r;
    esc_nxt      = esc_r;
    started_nxt  = started_r;
    first_nxt    = first_r;
    last_pos_nxt = last_pos_r;
    hit          = 1'b0;
    err          = 1'b0;
    status_c     = ST_DELIM;
    br           = open_kind(byte_r);

    case (mode_r)
      MODE_PLAIN: begin
        if (delim) begin
          hit = 1'b1;
        end else if (byte_r != CH_SPACE && byte_r != CH_TAB) begin
          if (!started_r) begin
            started_nxt = 1'b1;
            first_nxt   = pos_r;
          end
          if (is_quote(byte_r)) begin
            mode_nxt  = MODE_STRING;
            quote_nxt = byte_r;
            esc_nxt   = 1'b0;
          end else if (br.hit) begin
            mode_nxt  = MODE_BLOCK;
            kind_nxt  = br.kind;
            depth_nxt = DEPTH_ONE;
          end else begin
            last_pos_nxt = pos_r;
          end
        end
      end
      MODE_STRING, MODE_BLOCK_STRING: begin
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (byte_r == CH_BACKSLASH) begin
          esc_nxt = 1'b1;
        end else if (byte_r == quote_r) begin
          if (mode_r == MODE_BLOCK_STRING) begin
            mode_nxt = MODE_BLOCK;
          end else begin
            mode_nxt     = MODE_PLAIN;
            last_pos_nxt = pos_r;
          end
        end
      end
      MODE_BLOCK: begin
        if (byte_r == close_char(kind_r)) begin
          if (depth_r <= DEPTH_ONE) begin
            depth_nxt    = '0;
            mode_nxt     = MODE_PLAIN;
            last_pos_nxt = pos_r;
          end else begin
            depth_nxt = depth_r - DEPTH_ONE;
          end
        end else if (byte_r == open_char(kind_r)) begin
          if (depth_r >= DEPTH_MAX) begin
            hit = 1'b1;
            err = 1'b1;
          end else begin
            depth_nxt = depth_r + DEPTH_ONE;
          end
        end else if (is_quote(byte_r)) begin
          mode_nxt  = MODE_BLOCK_STRING;
          quote_nxt = byte_r;
          esc_nxt   = 1'b0;
        end
      end
      default: begin
        mode_nxt = MODE_PLAIN;
      end
    endcase

    if (!hit && last_r) begin
      hit = 1'b1;
      if (mode_nxt != MODE_PLAIN) begin
        err = 1'b1;
      end else begin
        status_c = eoe_r ? ST_END_ERR : ST_END;
      end
    end
    if (err) begin
      status_c = ST_UNTERM;
    end

    empty_c     = err || !started_nxt;
    res_first_c = empty_c ? '0 : 32'(first_nxt);
    res_last_c  = empty_c ? '0 : 32'(last_pos_nxt);

    if (hit) begin
      mode_nxt     = MODE_PLAIN;
      quote_nxt    = '0;
      kind_nxt     = KIND_PAREN;
      depth_nxt    = '0;
      esc_nxt      = 1'b0;
      started_nxt  = 1'b0;
      first_nxt    = '0;
      last_pos_nxt = '0;
    end
    pos_nxt = (hit && last_r) ? POSITION_BITS'(start_r) : pos_r + POS_ONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      delims_r    <= '0;
      count_r     <= '0;
      eoe_r       <= 1'b1;
      in_valid_r  <= 1'b0;
      mode_r      <= MODE_PLAIN;
      quote_r     <= '0;
      kind_r      <= KIND_PAREN;
      depth_r     <= '0;
      esc_r       <= 1'b0;
      started_r   <= 1'b0;
      first_r     <= '0;
      last_pos_r  <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        mode_r     <= mode_nxt;
        quote_r    <= quote_nxt;
        kind_r     <= kind_nxt;
        depth_r    <= depth_nxt;
        esc_r      <= esc_nxt;
        started_r  <= started_nxt;
        first_r    <= first_nxt;
        last_pos_r <= last_pos_nxt;
        pos_r      <= pos_nxt;
      end
      if (advance && hit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_START: begin
            start_r <= cfg_wdata[31:0];
            pos_r   <= POSITION_BITS'(cfg_wdata[31:0]);
          end
          REG_DELIMS: delims_r <= cfg_wdata;
          REG_COUNT:  count_r  <= cfg_wdata[3:0];
          REG_EOE:    eoe_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
    if (advance && hit) begin
      status_r    <= status_c;
      stop_r      <= 32'(pos_r);
      res_first_r <= res_first_c;
      res_last_r  <= res_last_c;
      empty_r     <= empty_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {7'b0, empty_r, res_last_r, res_first_r, stop_r};

  `QBFS_ASSERT_NOW(a_err_empty, clk, rst_n, out_valid_r && status_r == ST_UNTERM, empty_r)
  `QBFS_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid_r && empty_r,
                   res_first_r == '0 && res_last_r == '0)
  `QBFS_ASSERT_NOW(a_depth_mode, clk, rst_n, mode_r == MODE_PLAIN || mode_r == MODE_STRING,
                   depth_r == '0)
  `QBFS_ASSERT_NOW(a_depth_limit, clk, rst_n, mode_r == MODE_BLOCK || mode_r == MODE_BLOCK_STRING,
                   depth_r != '0 && depth_r <= DEPTH_MAX)
  `QBFS_ASSERT_NEXT(a_pos_reload, clk, rst_n, advance && last_r,
                    pos_r == POSITION_BITS'(start_r) && out_valid_r)

endmodule

// ===== test/qbfs_scan_checker.sv =====
// checker for the field scanner: predicts each field result and compares the output transfers
`timescale 1ns / 1ps

module qbfs_scan_checker
  import qbfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_addr,
  input  logic [63:0]  cfg_wdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tlast,   // last_byte
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [103:0] out_tdata,  // stop_position, field_first, field_last, field_empty, pad
  input  logic [1:0]   out_tuser,  // status
  output int           mismatch_count,
  output int           fields_pending,
  output int           fields_checked
);

  localparam int          NEST_LIMIT = 255;
  localparam int          MAX_DELIMS = 8;
  localparam logic [23:0] OPENERS    = 24'h7B5B28;
  localparam logic [23:0] CLOSERS    = 24'h7D5D29;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] stop_pos;
    logic [31:0] first_pos;
    logic [31:0] last_pos;
    logic        empty;
  } field_result_t;

  field_result_t expected_fields[$];
  int            errors = 0;
  int            checked = 0;

  // register shadows
  logic [31:0] start_pos;
  logic [63:0] delim_set;
  logic [3:0]  delim_cnt;
  logic        end_is_error;

  // scan state
  scan_mode_t  mode;
  logic [7:0]  quote_ch;
  logic [1:0]  kind;
  int          depth;
  logic        escaped;
  logic        started;
  logic [31:0] first_pos;
  logic [31:0] last_pos;
  logic [31:0] cur_pos;

  task automatic report(input string msg);
    errors++;
    if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic clear_scan();
    mode      = MODE_PLAIN;
    quote_ch  = 8'h00;
    kind      = KIND_PAREN;
    depth     = 0;
    escaped   = 1'b0;
    started   = 1'b0;
    first_pos = '0;
    last_pos  = '0;
  endtask

  function automatic logic ends_field(input logic [7:0] c);
    int n;
    n = (delim_cnt > MAX_DELIMS) ? MAX_DELIMS : delim_cnt;
    if (c == CH_NUL) return 1'b1;
    for (int i = 0; i < n; i++) begin
      if (delim_set[8*i +: 8] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic scan_byte(input logic [7:0] c, input logic fin);
    logic [31:0]   p;
    logic          hit;
    logic          err;
    logic          opens;
    logic [1:0]    st;
    logic [1:0]    k;
    field_result_t r;
    p     = cur_pos;
    hit   = 1'b0;
    err   = 1'b0;
    opens = 1'b0;
    st    = ST_DELIM;
    k     = KIND_PAREN;
    case (mode)
      MODE_PLAIN: begin
        for (int j = 0; j < 3; j++) begin
          if (!opens && c == OPENERS[8*j +: 8]) begin
            opens = 1'b1;
            k = j[1:0];
          end
        end
        if (ends_field(c)) begin
          hit = 1'b1;
        end else if (c != CH_SPACE && c != CH_TAB) begin
          if (!started) begin
            started   = 1'b1;
            first_pos = p;
          end
          if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            mode     = MODE_STRING;
            quote_ch = c;
            escaped  = 1'b0;
          end else if (opens) begin
            mode  = MODE_BLOCK;
            kind  = k;
            depth = 1;
          end else begin
            last_pos = p;
          end
        end
      end
      MODE_STRING, MODE_BLOCK_STRING: begin
        if (escaped) begin
          escaped = 1'b0;
        end else if (c == CH_BACKSLASH) begin
          escaped = 1'b1;
        end else if (c == quote_ch) begin
          if (mode == MODE_BLOCK_STRING) begin
            mode = MODE_BLOCK;
          end else begin
            mode     = MODE_PLAIN;
            last_pos = p;
          end
        end
      end
      default: begin
        if (c == CLOSERS[8*kind +: 8]) begin
          if (depth > 0) depth--;
          if (depth == 0) begin
            mode     = MODE_PLAIN;
            last_pos = p;
          end
        end else if (c == OPENERS[8*kind +: 8]) begin
          if (depth >= NEST_LIMIT) begin
            hit = 1'b1;
            err = 1'b1;
          end else begin
            depth++;
          end
        end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
          mode     = MODE_BLOCK_STRING;
          quote_ch = c;
          escaped  = 1'b0;
        end
      end
    endcase

    if (!hit && fin) begin
      hit = 1'b1;
      if (mode != MODE_PLAIN) err = 1'b1;
      else st = end_is_error ? ST_END_ERR : ST_END;
    end

    if (!hit) begin
      cur_pos = p + 32'd1;
      return;
    end

    r.stop_pos = p;
    if (err) begin
      r.status    = ST_UNTERM;
      r.first_pos = '0;
      r.last_pos  = '0;
      r.empty     = 1'b1;
    end else begin
      r.status = st;
      if (started) begin
        r.first_pos = first_pos;
        r.last_pos  = last_pos;
        r.empty     = 1'b0;
      end else begin
        r.first_pos = '0;
        r.last_pos  = '0;
        r.empty     = 1'b1;
      end
    end
    expected_fields.push_back(r);
    clear_scan();
    cur_pos = fin ? start_pos : p + 32'd1;
  endtask

  always @(posedge clk) begin
    field_result_t got;
    field_result_t want;
    if (!rst_n) begin
      start_pos    = '0;
      delim_set    = '0;
      delim_cnt    = '0;
      end_is_error = 1'b1;
      clear_scan();
      cur_pos = '0;
      expected_fields.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.status    = out_tuser;
        got.stop_pos  = out_tdata[31:0];
        got.first_pos = out_tdata[63:32];
        got.last_pos  = out_tdata[95:64];
        got.empty     = out_tdata[96];
        if (expected_fields.size() == 0) begin
          report($sformatf("result at stop position %0h with nothing pending", got.stop_pos));
        end else begin
          want = expected_fields.pop_front();
          checked++;
          if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.stop_pos !== want.stop_pos)
            report($sformatf("stop position %0h, expected %0h", got.stop_pos, want.stop_pos));
          if (got.first_pos !== want.first_pos)
            report($sformatf("field first %0h, expected %0h", got.first_pos, want.first_pos));
          if (got.last_pos !== want.last_pos)
            report($sformatf("field last %0h, expected %0h", got.last_pos, want.last_pos));
          if (got.empty !== want.empty)
            report($sformatf("field empty %0b, expected %0b", got.empty, want.empty));
        end
      end
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_START: begin
            start_pos = cfg_wdata[31:0];
            cur_pos   = cfg_wdata[31:0];
          end
          REG_DELIMS: delim_set    = cfg_wdata;
          REG_COUNT:  delim_cnt    = cfg_wdata[3:0];
          REG_EOE:    end_is_error = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) scan_byte(in_tdata, in_tlast);
    end
    mismatch_count <= errors;
    fields_pending <= expected_fields.size();
    fields_checked <= checked;
  end

endmodule

// ===== test/tb_top.sv =====
// testbench top for the field scanner: reset, register settings, byte stimulus and verdict
`timescale 1ns / 1ps

module tb_top
  import qbfs_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 750;
  localparam int PHASE_BYTES    = 120;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         cfg_wr_en  = 1'b0;
  logic [1:0]   cfg_addr   = REG_START;
  logic [63:0]  cfg_wdata  = '0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = '0;   // data_byte
  logic         in_tlast   = 1'b0; // last_byte
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;         // stop_position, field_first, field_last, field_empty, pad
  logic [1:0]   out_tuser;         // status

  int mismatches;
  int pending;
  int checked;

  logic [63:0] cur_delims  = '0;
  logic [3:0]  cur_count   = '0;
  int          bytes_sent  = 0;
  int          phase_bytes = 0;
  int          phases      = 0;
  bit          tx_steady   = 1'b0;
  bit          rx_steady   = 1'b0;
  int          stall_left  = 0;
  int          quiet_cycles = 0;

  always #6 clk = ~clk;

  quote_bracket_aware_field_scanner uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  qbfs_scan_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatches),
    .fields_pending (pending),
    .fields_checked (checked)
  );

  // watchdog on transfers
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (rx_steady || r < 70) begin
      out_tready <= 1'b1;
    end else if (r < 95) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(10, 40);
    end
    if ($urandom_range(0, 199) == 0) rx_steady <= !rx_steady;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if ($urandom_range(0, 99) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    phase_bytes++;
  endtask

  task automatic send_text(input string s, input logic fin_at_end);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin_at_end && (i == s.len() - 1));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic configure(input logic [31:0] sp, input logic [63:0] ds,
                           input logic [3:0] dc, input logic eoe);
    logic [63:0] junk;
    junk = {$urandom(), $urandom()};
    wait_drained();
    repeat (6) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_START;
    cfg_wdata <= {junk[63:32], sp};
    @(posedge clk);
    cfg_addr  <= REG_DELIMS;
    cfg_wdata <= ds;
    @(posedge clk);
    cfg_addr  <= REG_COUNT;
    cfg_wdata <= {junk[63:4], dc};
    @(posedge clk);
    cfg_addr  <= REG_EOE;
    cfg_wdata <= {junk[63:1], eoe};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_delims  = ds;
    cur_count   = dc;
    phases++;
    phase_bytes = 0;
  endtask

  function automatic logic [7:0] word_char();
    if ($urandom_range(0, 99) < 85) begin
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(8'h30, 8'h39));
      return 8'($urandom_range(8'h61, 8'h7A));
    end
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  function automatic logic [7:0] any_delim();
    int n;
    n = (cur_count > 8) ? 8 : cur_count;
    if (n == 0 || $urandom_range(0, 4) == 0) return CH_NUL;
    return cur_delims[8*$urandom_range(0, n - 1) +: 8];
  endfunction

  function automatic logic [63:0] mixed_delims();
    string       punct;
    logic [63:0] d;
    punct = ",;:|=&/!";
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(0, 99) < 75) d[8*i +: 8] = punct[$urandom_range(0, 7)];
      else d[8*i +: 8] = 8'($urandom_range(0, 255));
    end
    return d;
  endfunction

  task automatic send_blanks(input int n);
    repeat (n) send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
  endtask

  task automatic send_quoted();
    logic [7:0] q;
    int         r;
    q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
    send_byte(q, 1'b0);
    repeat ($urandom_range(0, 4)) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte($urandom_range(0, 1) ? q : word_char(), 1'b0);
      end else if (r < 35) begin
        send_byte(any_delim(), 1'b0);
      end else if (r < 45) begin
        send_blanks(1);
      end else begin
        send_byte(word_char(), 1'b0);
      end
    end
    send_byte(q, 1'b0);
  endtask

  task automatic send_block(input logic [1:0] k, input int lvl);
    int r;
    send_byte(8'h28 + ((k == KIND_PAREN) ? 8'd0 : (k == KIND_SQUARE) ? 8'd51 : 8'd83), 1'b0);
    repeat ($urandom_range(0, 4)) begin
      r = $urandom_range(0, 99);
      if (r < 35) send_byte(word_char(), 1'b0);
      else if (r < 50) send_byte(any_delim(), 1'b0);
      else if (r < 65) send_quoted();
      else if (r < 80 && lvl < 3) send_block(k, lvl + 1);
      else send_blanks(1);
    end
    send_byte(8'h29 + ((k == KIND_PAREN) ? 8'd0 : (k == KIND_SQUARE) ? 8'd52 : 8'd84), 1'b0);
  endtask

  task automatic send_field();
    int r;
    send_blanks($urandom_range(0, 2));
    repeat ($urandom_range(0, 3)) begin
      r = $urandom_range(0, 99);
      if (r < 45) repeat ($urandom_range(1, 4)) send_byte(word_char(), 1'b0);
      else if (r < 70) send_quoted();
      else send_block(2'($urandom_range(0, 2)), 1);
      if ($urandom_range(0, 2) == 0) send_blanks(1);
    end
    r = $urandom_range(0, 99);
    if (r < 75) begin
      send_byte(any_delim(), $urandom_range(0, 9) == 0);
    end else if (r < 85) begin
      send_byte(word_char(), 1'b1);
    end else if (r < 92) begin
      // stream ends inside a string or a block
      if ($urandom_range(0, 1)) send_byte(CH_DQUOTE, 1'b0);
      else send_byte(8'h7B, 1'b0);
      send_byte($urandom_range(0, 1) ? CH_BACKSLASH : word_char(), 1'b1);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
  endtask

  task automatic send_deep(input int n);
    logic [1:0] k;
    k = 2'($urandom_range(0, 2));
    repeat (n) send_byte((k == KIND_PAREN) ? 8'h28 : (k == KIND_SQUARE) ? 8'h5B : 8'h7B, 1'b0);
    repeat (n) send_byte((k == KIND_PAREN) ? 8'h29 : (k == KIND_SQUARE) ? 8'h5D : 8'h7D, 1'b0);
    send_byte(CH_NUL, 1'b0);
  endtask

  initial begin
    int          r;
    logic [31:0] sp;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: delimiters ',' ';' '[' with positions wrapping
    configure(32'hFFFF_FFFA, 64'h0000_0000_005B_3B2C, 4'd3, 1'b1);
    send_text(" a ,", 1'b0);
    send_text("\t;", 1'b0);
    send_text("\"x,\\\"\",", 1'b0);
    send_text("(a(,))", 1'b0);
    send_byte(CH_NUL, 1'b0);
    send_text("[", 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("'a\\", 1'b1);

    // random phases
    while (bytes_sent < RANDOM_BYTES + 25) begin
      if (phase_bytes >= PHASE_BYTES || phases == 1) begin
        if (phases > 1) send_byte(word_char(), 1'b1);
        case (phases)
          1: configure(32'h0, mixed_delims(), 4'd8, 1'b0);
          2: configure(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
          3: configure($urandom(), 64'h0, 4'd0, 1'($urandom_range(0, 1)));
          default: begin
            r  = $urandom_range(0, 3);
            sp = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFF8 : $urandom();
            configure(sp, mixed_delims(), 4'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)));
          end
        endcase
        if (phases == 3) send_deep(256);
        else if (phases == 5) send_deep($urandom_range(254, 257));
      end
      r = $urandom_range(0, 99);
      if (r < 8) send_noise();
      else if (r < 11) wait_drained();
      else send_field();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d bytes over %0d register settings, %0d results checked",
             bytes_sent, phases, checked);
    $display("fields with blanks, quotes, escapes, nested brackets, deep nesting and noise");
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== quote_bracket_aware_field_scanner.f =====
+incdir+hdl
hdl/qbfs_pkg.sv
hdl/quote_bracket_aware_field_scanner.sv
test/qbfs_scan_checker.sv
test/tb_top.sv
